// File: hw/rtl/position_frame_deframer_defines.svh
// ----------------------------------------------------------------------------
// position_frame_deframer_defines
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef POSITION_FRAME_DEFRAMER_DEFINES_SVH
`define POSITION_FRAME_DEFRAMER_DEFINES_SVH

// clocked assertion, ignored while reset is high
`define PFD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion, also checked while reset is high
`define PFD_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/pfd_pkg.sv
// ----------------------------------------------------------------------------
// pfd_pkg
// Types and constants of the position frame deframer.
// ----------------------------------------------------------------------------
package pfd_pkg;

   localparam int BYTE_W    = 8;
   localparam int POS_W     = 16;
   localparam int CNT_OUT_W = 32;
   localparam int STATUS_W  = 2;

   localparam logic [BYTE_W-1:0] HDR0_BYTE  = 8'h55;
   localparam logic [BYTE_W-1:0] HDR1_BYTE  = 8'hAA;
   localparam logic [BYTE_W-1:0] TAIL_BYTE  = 8'hCC;
   localparam logic [BYTE_W-1:0] MODE_RESET = 8'h10;

   typedef enum logic [3:0] {
      PH_HUNT = 4'd0,
      PH_SYNC = 4'd1,
      PH_MODE = 4'd2,
      PH_XH   = 4'd3,
      PH_XL   = 4'd4,
      PH_YH   = 4'd5,
      PH_YL   = 4'd6,
      PH_CHK  = 4'd7,
      PH_TAIL = 4'd8
   } phase_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_ACCEPTED   = 2'd0,
      ST_BAD_TAIL   = 2'd1,
      ST_BAD_CHECK  = 2'd2,
      ST_OTHER_MODE = 2'd3
   } status_type;

   typedef struct packed {
      logic                     done;
      logic [BYTE_W-1:0]        tail;
      logic [BYTE_W-1:0]        mode;
      logic signed [POS_W-1:0]  x;
      logic signed [POS_W-1:0]  y;
      logic [BYTE_W-1:0]        check;
      logic [BYTE_W-1:0]        xsum;
   } frame_type;

   typedef struct packed {
      logic [STATUS_W-1:0]      frame_status;
      logic [BYTE_W-1:0]        mode_code;
      logic signed [POS_W-1:0]  x_position;
      logic signed [POS_W-1:0]  y_position;
      logic [CNT_OUT_W-1:0]     frames_seen;
      logic [CNT_OUT_W-1:0]     frames_bad;
   } result_type;

endpackage

// File: hw/rtl/pfd_req_if.sv
// ----------------------------------------------------------------------------
// pfd_req_if
// Request channel carrying one received byte per request.
// ----------------------------------------------------------------------------
interface pfd_req_if;
   import pfd_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);

endinterface

// File: hw/rtl/pfd_rsp_if.sv
// ----------------------------------------------------------------------------
// pfd_rsp_if
// Result channel carrying one decoded frame per transfer.
// ----------------------------------------------------------------------------
interface pfd_rsp_if;
   import pfd_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [STATUS_W-1:0]     frame_status;
   logic [BYTE_W-1:0]       mode_code;
   logic signed [POS_W-1:0] x_position;
   logic signed [POS_W-1:0] y_position;
   logic [CNT_OUT_W-1:0]    frames_seen;
   logic [CNT_OUT_W-1:0]    frames_bad;

   modport source (output valid, output frame_status, output mode_code,
                   output x_position, output y_position, output frames_seen,
                   output frames_bad, input ready);
   modport sink   (input valid, input frame_status, input mode_code,
                   input x_position, input y_position, input frames_seen,
                   input frames_bad, output ready);

endinterface

// File: hw/rtl/pfd_framer.sv
// ----------------------------------------------------------------------------
// pfd_framer
// Input register and header hunt / byte collection state machine.
// ----------------------------------------------------------------------------
module pfd_framer (
   input  logic              clock,
   input  logic              reset,
   pfd_req_if.sink           req_bus,
   input  logic              out_room,
   output pfd_pkg::frame_type frame
);
   import pfd_pkg::*;

   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff, in_byte_in;
   phase_type         phase_ff, phase_in;
   logic [BYTE_W-1:0] xsum_ff, xsum_in;
   logic [BYTE_W-1:0] mode_ff, mode_in;
   logic [BYTE_W-1:0] xh_ff, xh_in;
   logic [BYTE_W-1:0] xl_ff, xl_in;
   logic [BYTE_W-1:0] yh_ff, yh_in;
   logic [BYTE_W-1:0] yl_ff, yl_in;
   logic [BYTE_W-1:0] chk_ff, chk_in;
   logic              advance;
   logic              take;

   assign advance       = in_valid_ff & out_room;
   assign req_bus.ready = ~in_valid_ff | out_room;
   assign take          = req_bus.valid & req_bus.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (take) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_bus.rx_byte;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      phase_in = phase_ff;
      xsum_in  = xsum_ff;
      mode_in  = mode_ff;
      xh_in    = xh_ff;
      xl_in    = xl_ff;
      yh_in    = yh_ff;
      yl_in    = yl_ff;
      chk_in   = chk_ff;
      if (advance) begin
         case (phase_ff)
            PH_SYNC: begin
               if (in_byte_ff == HDR1_BYTE) begin
                  phase_in = PH_MODE;
                  xsum_in  = '0;
               end else if (in_byte_ff == HDR0_BYTE) begin
                  phase_in = PH_SYNC;
               end else begin
                  phase_in = PH_HUNT;
               end
            end
            PH_MODE: begin
               mode_in  = in_byte_ff;
               xsum_in  = xsum_ff ^ in_byte_ff;
               phase_in = PH_XH;
            end
            PH_XH: begin
               xh_in    = in_byte_ff;
               xsum_in  = xsum_ff ^ in_byte_ff;
               phase_in = PH_XL;
            end
            PH_XL: begin
               xl_in    = in_byte_ff;
               xsum_in  = xsum_ff ^ in_byte_ff;
               phase_in = PH_YH;
            end
            PH_YH: begin
               yh_in    = in_byte_ff;
               xsum_in  = xsum_ff ^ in_byte_ff;
               phase_in = PH_YL;
            end
            PH_YL: begin
               yl_in    = in_byte_ff;
               xsum_in  = xsum_ff ^ in_byte_ff;
               phase_in = PH_CHK;
            end
            PH_CHK: begin
               chk_in   = in_byte_ff;
               phase_in = PH_TAIL;
            end
            PH_TAIL: begin
               phase_in = PH_HUNT;
            end
            default: begin
               phase_in = (in_byte_ff == HDR0_BYTE) ? PH_SYNC : PH_HUNT;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         phase_ff    <= PH_HUNT;
         xsum_ff     <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         phase_ff    <= phase_in;
         xsum_ff     <= xsum_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      mode_ff    <= mode_in;
      xh_ff      <= xh_in;
      xl_ff      <= xl_in;
      yh_ff      <= yh_in;
      yl_ff      <= yl_in;
      chk_ff     <= chk_in;
   end

   assign frame.done  = advance & (phase_ff == PH_TAIL);
   assign frame.tail  = in_byte_ff;
   assign frame.mode  = mode_ff;
   assign frame.x     = {xh_ff, xl_ff};
   assign frame.y     = {yh_ff, yl_ff};
   assign frame.check = chk_ff;
   assign frame.xsum  = xsum_ff;

endmodule

// File: hw/rtl/pfd_judge.sv
// ----------------------------------------------------------------------------
// pfd_judge
// Frame checks, frame and error counters, mode register.
// ----------------------------------------------------------------------------
module pfd_judge #(
   parameter int COUNTER_WIDTH = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [pfd_pkg::BYTE_W-1:0] csr_wr_data,
   input  pfd_pkg::frame_type        frame,
   output logic                      push,
   output pfd_pkg::result_type       result
);
   import pfd_pkg::*;

   logic [BYTE_W-1:0]        mode_ff;
   logic [COUNTER_WIDTH-1:0] seen_ff, seen_in;
   logic [COUNTER_WIDTH-1:0] bad_ff, bad_in;
   status_type               status;
   logic [CNT_OUT_W-1:0]     seen_out;
   logic [CNT_OUT_W-1:0]     bad_out;

   always_comb begin
      seen_in = seen_ff;
      bad_in  = bad_ff;
      status  = ST_ACCEPTED;
      if (frame.tail != TAIL_BYTE) begin
         status = ST_BAD_TAIL;
      end else if (frame.check != ~frame.xsum) begin
         status = ST_BAD_CHECK;
      end else if (frame.mode != mode_ff) begin
         status = ST_OTHER_MODE;
      end
      if (frame.done) begin
         seen_in = seen_ff + 1'b1;
         if (status == ST_BAD_TAIL || status == ST_BAD_CHECK) begin
            bad_in = bad_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_RESET;
         seen_ff <= '0;
         bad_ff  <= '0;
      end else begin
         if (csr_wr_en) begin
            mode_ff <= csr_wr_data;
         end
         seen_ff <= seen_in;
         bad_ff  <= bad_in;
      end
   end

   generate
      if (COUNTER_WIDTH >= CNT_OUT_W) begin : g_trunc
         assign seen_out = seen_in[CNT_OUT_W-1:0];
         assign bad_out  = bad_in[CNT_OUT_W-1:0];
      end else begin : g_ext
         assign seen_out = {{(CNT_OUT_W-COUNTER_WIDTH){1'b0}}, seen_in};
         assign bad_out  = {{(CNT_OUT_W-COUNTER_WIDTH){1'b0}}, bad_in};
      end
   endgenerate

   assign push                = frame.done;
   assign result.frame_status = status;
   assign result.mode_code    = frame.mode;
   assign result.x_position   = frame.x;
   assign result.y_position   = frame.y;
   assign result.frames_seen  = seen_out;
   assign result.frames_bad   = bad_out;

endmodule

// File: hw/rtl/pfd_rsp_buf.sv
// ----------------------------------------------------------------------------
// pfd_rsp_buf
// Result register with one skid entry behind it.
// ----------------------------------------------------------------------------
module pfd_rsp_buf (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  pfd_pkg::result_type push_data,
   output logic                room,
   pfd_rsp_if.source           rsp_bus
);
   import pfd_pkg::*;

   logic       main_valid_ff, main_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type main_ff, main_in;
   result_type skid_ff, skid_in;
   logic       pop;

   assign pop  = main_valid_ff & rsp_bus.ready;
   assign room = ~skid_valid_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (~main_valid_ff | pop) begin
         if (skid_valid_ff) begin
            main_valid_in = 1'b1;
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = push;
            main_in       = push_data;
         end
      end else if (push & ~skid_valid_ff) begin
         skid_valid_in = 1'b1;
         skid_in       = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign rsp_bus.valid        = main_valid_ff;
   assign rsp_bus.frame_status = main_ff.frame_status;
   assign rsp_bus.mode_code    = main_ff.mode_code;
   assign rsp_bus.x_position   = main_ff.x_position;
   assign rsp_bus.y_position   = main_ff.y_position;
   assign rsp_bus.frames_seen  = main_ff.frames_seen;
   assign rsp_bus.frames_bad   = main_ff.frames_bad;

endmodule

// File: hw/rtl/position_frame_deframer.sv
// ----------------------------------------------------------------------------
// position_frame_deframer
// Hunts for the 0x55 0xAA header in a byte stream, collects the seven frame
// bytes, checks tail and checksum and reports status, mode and position.
//
//   channel   direction  payload
//   req_bus   in         rx_byte
//   rsp_bus   out        frame_status, mode_code, x_position, y_position,
//                        frames_seen, frames_bad
//   csr       in         accepted_mode write (csr_wr_en, csr_wr_data)
//
// one request per clock sustained; a request is held in the input register,
// and a frame's result is registered as its ninth byte leaves that register.
// throughput is set by the single input register feeding the phase machine.
// synchronous active-high reset clears phase and counters, sets mode to 0x10.
// a stalled result parks in a one-entry skid; requests stop only when the
// skid is also full.
// ----------------------------------------------------------------------------
module position_frame_deframer #(
   parameter int COUNTER_WIDTH = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   pfd_req_if.sink                    req_bus,
   pfd_rsp_if.source                  rsp_bus,
   input  logic                       csr_wr_en,
   input  logic [pfd_pkg::BYTE_W-1:0] csr_wr_data
);
   import pfd_pkg::*;

   frame_type  frame;
   result_type result;
   logic       push;
   logic       room;

   pfd_framer u_framer (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .out_room (room),
      .frame    (frame)
   );

   pfd_judge #(
      .COUNTER_WIDTH (COUNTER_WIDTH)
   ) u_judge (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .frame       (frame),
      .push        (push),
      .result      (result)
   );

   pfd_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (result),
      .room      (room),
      .rsp_bus   (rsp_bus)
   );

endmodule

// File: hw/rtl/pfd_checker.sv
// ----------------------------------------------------------------------------
// pfd_checker
// Port-level checks of the position frame deframer, bound to the top level.
// ----------------------------------------------------------------------------
`include "position_frame_deframer_defines.svh"

module pfd_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [pfd_pkg::STATUS_W-1:0]  frame_status,
   input logic [pfd_pkg::BYTE_W-1:0]    mode_code,
   input logic [pfd_pkg::POS_W-1:0]     x_position,
   input logic [pfd_pkg::POS_W-1:0]     y_position,
   input logic [pfd_pkg::CNT_OUT_W-1:0] frames_seen,
   input logic [pfd_pkg::CNT_OUT_W-1:0] frames_bad
);
   import pfd_pkg::*;

   // stalled result keeps its payload
   `PFD_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(frame_status) && $stable(mode_code) && $stable(x_position) && $stable(y_position) && $stable(frames_seen) && $stable(frames_bad), "result changed while stalled")

   // no result right after reset
   `PFD_ASSERT_ALWAYS(a_rst_clear, clock, $past(reset) |-> !rsp_valid, "result valid after reset")

   // requests back up only behind a waiting result
   `PFD_ASSERT(a_ready_back, clock, reset, !req_ready |-> rsp_valid, "request stalled with no result pending")

   // a stall on requests needs a result stalled the cycle before
   `PFD_ASSERT(a_ready_cause, clock, reset, !req_ready && !$past(reset) |-> $past(rsp_valid) && !$past(rsp_ready), "request stall without output stall")

endmodule

bind position_frame_deframer pfd_checker u_pfd_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_bus.valid),
   .req_ready    (req_bus.ready),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .frame_status (rsp_bus.frame_status),
   .mode_code    (rsp_bus.mode_code),
   .x_position   (rsp_bus.x_position),
   .y_position   (rsp_bus.y_position),
   .frames_seen  (rsp_bus.frames_seen),
   .frames_bad   (rsp_bus.frames_bad)
);

// File: dv/tb_position_frame_deframer.sv
// ----------------------------------------------------------------------------
// tb_position_frame_deframer
// Self-checking bench for the position frame deframer. Byte streams go in
// through the request channel in bursts with random gaps. The streams hold
// good and bad frames with random content, truncated frames and noise. A
// decoder kept in the bench predicts every frame report, and each report is
// checked field by field while the result side stalls at random. The run
// repeats under several accepted-mode settings, the extremes among them.
// ----------------------------------------------------------------------------
module tb_position_frame_deframer;
   timeunit 1ns;
   timeprecision 1ps;

   import pfd_pkg::*;

   localparam int STAGES       = 5;
   localparam int STAGE_BYTES  = 370;
   localparam int DRAIN_CYCLES = 16;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_wr_en = 1'b0;
   logic [BYTE_W-1:0]   csr_wr_data = '0;

   pfd_req_if req_ch ();
   pfd_rsp_if rsp_ch ();

   position_frame_deframer u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_ch),
      .rsp_bus     (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   logic [BYTE_W-1:0]    byte_backlog[$];
   result_type           frames_expected[$];
   int unsigned          bytes_queued = 0;
   int unsigned          frames_checked = 0;
   int unsigned          mismatches = 0;
   int                   cfg_stage = 0;
   bit                   req_fire = 1'b0;
   bit                   hold_rsp = 1'b0;
   int                   burst_left = 0;
   int                   gap_left = 0;
   int                   stall_span = 0;
   int                   stall_style = 0;

   // frame decoder state
   phase_type            dec_phase;
   logic [BYTE_W-1:0]    dec_bytes [6];
   logic [BYTE_W-1:0]    dec_xsum;
   logic [BYTE_W-1:0]    dec_mode;
   logic [CNT_OUT_W-1:0] dec_seen;
   logic [CNT_OUT_W-1:0] dec_bad;

   initial begin
      req_ch.valid   = 1'b0;
      req_ch.rx_byte = '0;
      rsp_ch.ready   = 1'b0;
   end

   function automatic void push_byte(logic [BYTE_W-1:0] b);
      byte_backlog.push_back(b);
      bytes_queued++;
   endfunction

   function automatic void queue_frame(logic [BYTE_W-1:0] mode, logic [POS_W-1:0] x,
                                       logic [POS_W-1:0] y, bit bad_check,
                                       logic [BYTE_W-1:0] tail);
      logic [BYTE_W-1:0] sum;
      logic [BYTE_W-1:0] check;
      sum = mode ^ x[15:8] ^ x[7:0] ^ y[15:8] ^ y[7:0];
      check = ~sum;
      if (bad_check) begin
         check = check ^ 8'($urandom_range(1, 255));
      end
      push_byte(HDR0_BYTE);
      push_byte(HDR1_BYTE);
      push_byte(mode);
      push_byte(x[15:8]);
      push_byte(x[7:0]);
      push_byte(y[15:8]);
      push_byte(y[7:0]);
      push_byte(check);
      push_byte(tail);
   endfunction

   function automatic void decode_byte(logic [BYTE_W-1:0] b);
      result_type r;
      int         idx;
      case (dec_phase)
         PH_SYNC: begin
            if (b == HDR1_BYTE) begin
               dec_phase = PH_MODE;
               dec_xsum  = '0;
            end else if (b == HDR0_BYTE) begin
               dec_phase = PH_SYNC;
            end else begin
               dec_phase = PH_HUNT;
            end
         end
         PH_MODE, PH_XH, PH_XL, PH_YH, PH_YL, PH_CHK: begin
            idx = int'(dec_phase) - int'(PH_MODE);
            dec_bytes[idx] = b;
            if (dec_phase != PH_CHK) begin
               dec_xsum = dec_xsum ^ b;
            end
            dec_phase = phase_type'(dec_phase + 1);
         end
         PH_TAIL: begin
            dec_phase = PH_HUNT;
            dec_seen  = dec_seen + 1;
            // tail is judged before the checksum
            if (b != TAIL_BYTE) begin
               r.frame_status = ST_BAD_TAIL;
               dec_bad = dec_bad + 1;
            end else if (dec_bytes[5] != ~dec_xsum) begin
               r.frame_status = ST_BAD_CHECK;
               dec_bad = dec_bad + 1;
            end else if (dec_bytes[0] == dec_mode) begin
               r.frame_status = ST_ACCEPTED;
            end else begin
               r.frame_status = ST_OTHER_MODE;
            end
            r.mode_code   = dec_bytes[0];
            r.x_position  = {dec_bytes[1], dec_bytes[2]};
            r.y_position  = {dec_bytes[3], dec_bytes[4]};
            r.frames_seen = dec_seen;
            r.frames_bad  = dec_bad;
            frames_expected.push_back(r);
         end
         default: begin
            dec_phase = (b == HDR0_BYTE) ? PH_SYNC : PH_HUNT;
         end
      endcase
   endfunction

   task automatic report_mismatch(string msg);
      mismatches++;
      $display("%0t ns frame %0d: %s", $time, frames_checked, msg);
   endtask

   task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
      end
   endtask

   task automatic wait_drained();
      while (byte_backlog.size() != 0 || frames_expected.size() != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // sample both channels and the register write
   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         dec_phase = PH_HUNT;
         dec_xsum  = '0;
         dec_mode  = MODE_RESET;
         dec_seen  = '0;
         dec_bad   = '0;
         req_fire  = 1'b0;
      end else begin
         if (csr_wr_en) begin
            dec_mode = csr_wr_data;
         end
         req_fire = req_ch.valid && req_ch.ready;
         if (req_fire) begin
            decode_byte(req_ch.rx_byte);
            void'(byte_backlog.pop_front());
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (frames_expected.size() == 0) begin
               report_mismatch("frame report with none expected");
            end else begin
               want = frames_expected.pop_front();
               check_field("frame_status", rsp_ch.frame_status, want.frame_status);
               check_field("mode_code", rsp_ch.mode_code, want.mode_code);
               check_field("x_position", rsp_ch.x_position, want.x_position);
               check_field("y_position", rsp_ch.y_position, want.y_position);
               check_field("frames_seen", rsp_ch.frames_seen, want.frames_seen);
               check_field("frames_bad", rsp_ch.frames_bad, want.frames_bad);
            end
            frames_checked++;
         end
      end
   end

   // request driver, bursts with gaps
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (req_ch.valid && !req_fire) begin
         // keep offering the same request
      end else if (gap_left > 0) begin
         req_ch.valid <= 1'b0;
         gap_left--;
      end else if (byte_backlog.size() == 0) begin
         req_ch.valid <= 1'b0;
      end else begin
         req_ch.valid   <= 1'b1;
         req_ch.rx_byte <= byte_backlog[0];
         if (burst_left > 0) begin
            burst_left--;
         end else begin
            burst_left = $urandom_range(0, 40);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         end
      end
   end

   // result side stall pattern
   always @(negedge clock) begin
      if (reset || hold_rsp) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (stall_span == 0) begin
            stall_span  = $urandom_range(4, 60);
            stall_style = $urandom_range(0, 3);
         end
         stall_span--;
         case (stall_style)
            0: rsp_ch.ready <= 1'b1;
            1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
            2: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ch.ready <= (stall_span % 3 != 0);
         endcase
      end
   end

   // long result hold-off so the block backs up into the request side
   initial begin
      wait (cfg_stage == 2);
      repeat (40) @(negedge clock);
      hold_rsp <= 1'b1;
      repeat (300) @(negedge clock);
      hold_rsp <= 1'b0;
   end

   initial begin
      logic [BYTE_W-1:0] stage_mode;
      int unsigned       stage_end;
      int unsigned       roll;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int s = 0; s < STAGES; s++) begin
         wait_drained();
         case (s)
            0: stage_mode = MODE_RESET;
            1: stage_mode = 8'h00;
            2: stage_mode = 8'hFF;
            default: stage_mode = 8'($urandom_range(0, 255));
         endcase
         if (s > 0) begin
            csr_wr_en   <= 1'b1;
            csr_wr_data <= stage_mode;
            @(negedge clock);
            csr_wr_en   <= 1'b0;
            @(negedge clock);
         end
         cfg_stage = s;

         if (s == 0) begin
            // doubled sync byte, extreme positions
            push_byte(HDR0_BYTE);
            queue_frame(MODE_RESET, 16'h8000, 16'h7FFF, 1'b0, TAIL_BYTE);
            // header bytes inside the frame, other mode
            queue_frame(8'hAA, 16'h55AA, 16'h55AA, 1'b0, TAIL_BYTE);
            // bad tail wins over bad checksum
            queue_frame(8'hFF, 16'hFFFF, 16'h0000, 1'b1, 8'h00);
         end

         stage_end = bytes_queued + STAGE_BYTES;
         while (bytes_queued < stage_end) begin
            roll = $urandom_range(0, 99);
            if (roll < 80) begin
               if ($urandom_range(0, 3) == 0) begin
                  push_byte(8'($urandom_range(0, 255)));
               end
               queue_frame(($urandom_range(0, 1) == 1) ? stage_mode : 8'($urandom),
                           16'($urandom), 16'($urandom),
                           $urandom_range(0, 5) == 0,
                           ($urandom_range(0, 5) == 0) ? 8'($urandom) : TAIL_BYTE);
            end else if (roll < 90) begin
               // truncated frame
               push_byte(HDR0_BYTE);
               push_byte(HDR1_BYTE);
               repeat ($urandom_range(0, 6)) push_byte(8'($urandom));
            end else begin
               repeat ($urandom_range(1, 6)) begin
                  push_byte(($urandom_range(0, 1) == 1) ? HDR0_BYTE : 8'($urandom));
               end
            end
         end
      end

      wait_drained();
      if (mismatches == 0 && frames_expected.size() == 0) begin
         $display("tb_position_frame_deframer: clean");
      end else begin
         $display("tb_position_frame_deframer: errors");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("tb_position_frame_deframer: errors");
      $finish;
   end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/pfd_pkg.sv
hw/rtl/pfd_req_if.sv
hw/rtl/pfd_rsp_if.sv
hw/rtl/pfd_framer.sv
hw/rtl/pfd_judge.sv
hw/rtl/pfd_rsp_buf.sv
hw/rtl/position_frame_deframer.sv
hw/rtl/pfd_checker.sv
dv/tb_position_frame_deframer.sv
